### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/snd_pkg.sv
// types, constants and helper functions of the nearest vehicle dispatch unit
package snd_pkg;

   localparam int STATION_COUNT   = 16;
   localparam int NUM_VEHICLES    = 32;
   localparam int TIME_BITS       = 32;
   localparam int TRIP_BITS       = 16;
   localparam int COUNT_BITS      = 6;
   localparam int STATION_BITS    = (STATION_COUNT > 1) ? $clog2(STATION_COUNT) : 1;
   localparam int VEH_BITS        = (NUM_VEHICLES > 1) ? $clog2(NUM_VEHICLES) : 1;
   localparam int TABLE_DEPTH     = STATION_COUNT * STATION_COUNT;
   localparam int TABLE_ADDR_BITS = $clog2(TABLE_DEPTH);

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(32);

   typedef logic [TIME_BITS-1:0]       tick_type;
   typedef logic [STATION_BITS-1:0]    station_type;
   typedef logic [VEH_BITS-1:0]        veh_idx_type;
   typedef logic [TRIP_BITS-1:0]       trip_type;
   typedef logic [TABLE_ADDR_BITS-1:0] table_addr_type;

   localparam tick_type TIME_MAX = '1;

   typedef enum logic [1:0] {
      FUNC_LOAD_TRIP = 2'd0,
      FUNC_PLACE     = 2'd1,
      FUNC_REQUEST   = 2'd2,
      FUNC_UNUSED    = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [3:0]  table_row;
      logic [3:0]  table_col;
      logic [15:0] trip_ticks;
      logic [4:0]  vehicle_slot;
      logic [3:0]  place_station;
      logic [31:0] place_arrive;
      logic [3:0]  pax_origin;
      logic [3:0]  pax_destin;
      logic [31:0] pax_arrive;
   } req_payload_type;

   typedef struct packed {
      logic        assigned;
      logic [4:0]  chosen_vehicle;
      logic [3:0]  start_station;
      logic [31:0] pickup_time;
      logic [31:0] dropoff_time;
   } rsp_payload_type;

   typedef struct packed {
      station_type station;
      tick_type    arrive;
   } fleet_entry_type;

   // one vehicle after the empty trip lookup
   typedef struct packed {
      veh_idx_type idx;
      station_type station;
      trip_type    empty;
      tick_type    arrive;
   } cand_type;

   typedef struct packed {
      veh_idx_type idx;
      station_type station;
      tick_type    arrive;
   } best_type;

   function automatic tick_type sat_add(tick_type a, tick_type b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
   endfunction

   function automatic tick_type clamp_in(logic [31:0] v);
      logic [63:0] wide;
      wide = 64'(v);
      if (wide > 64'(TIME_MAX)) return TIME_MAX;
      return TIME_BITS'(wide);
   endfunction

   function automatic logic station_ok(logic [3:0] s);
      return int'(s) < STATION_COUNT;
   endfunction

   function automatic logic slot_ok(logic [4:0] v);
      return int'(v) < NUM_VEHICLES;
   endfunction

   function automatic table_addr_type table_addr(station_type from, station_type to);
      return TABLE_ADDR_BITS'(int'(from) * STATION_COUNT + int'(to));
   endfunction

   // index of the last vehicle scanned
   function automatic veh_idx_type count_last(logic [COUNT_BITS-1:0] c);
      int n;
      n = int'(c);
      if (n == 0) n = 1;
      if (n > NUM_VEHICLES) n = NUM_VEHICLES;
      return VEH_BITS'(n - 1);
   endfunction

endpackage

### hw/rtl/snd_if.sv
// request and response channel interfaces
interface snd_req_if;
   logic                     valid;
   logic                     ready;
   snd_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface snd_rsp_if;
   logic                     valid;
   logic                     ready;
   snd_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/snd_trip_ram.sv
// station-to-station trip time memory, one write and one registered read port
module snd_trip_ram (
   input  logic                    clock,
   input  logic                    wr_en,
   input  snd_pkg::table_addr_type wr_addr,
   input  snd_pkg::trip_type       wr_data,
   input  snd_pkg::table_addr_type rd_addr,
   output snd_pkg::trip_type       rd_data
);
   import snd_pkg::*;

   trip_type mem_ff [TABLE_DEPTH];
   trip_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/snd_fleet_ram.sv
// per-vehicle station and arrival memory, entries read as zero until written
module snd_fleet_ram (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  snd_pkg::veh_idx_type     wr_addr,
   input  snd_pkg::fleet_entry_type wr_entry,
   input  snd_pkg::veh_idx_type     rd_addr,
   output snd_pkg::fleet_entry_type rd_entry
);
   import snd_pkg::*;

   fleet_entry_type             mem_ff [NUM_VEHICLES];
   logic [NUM_VEHICLES-1:0]     written_ff;
   logic [NUM_VEHICLES-1:0]     written_in;
   fleet_entry_type             rd_entry_ff;
   logic                        rd_written_ff;

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff    <= written_in;
         rd_written_ff <= written_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem_ff[rd_addr];
   end

   assign rd_entry = rd_written_ff ? rd_entry_ff : '0;

endmodule

### hw/rtl/snd_best_select.sv
// running choice of the vehicle with the least passenger wait
module snd_best_select (
   input  logic              clock,
   input  logic              cand_vld,
   input  snd_pkg::cand_type cand,
   input  snd_pkg::tick_type parr,
   output snd_pkg::best_type best
);
   import snd_pkg::*;

   tick_type  wait_now;
   logic      take;
   tick_type  best_wait_ff;
   trip_type  best_empty_ff;
   best_type  best_ff;

   assign wait_now = (cand.arrive > parr) ? cand.arrive - parr : '0;

   // least wait, then shorter empty trip, then later arrival, then lower index
   always_comb begin
      take = (cand.idx == '0) || (wait_now < best_wait_ff);
      if (wait_now == best_wait_ff) begin
         if (cand.empty < best_empty_ff) begin
            take = 1'b1;
         end else if (cand.empty == best_empty_ff && cand.arrive > best_ff.arrive) begin
            take = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cand_vld && take) begin
         best_wait_ff   <= wait_now;
         best_empty_ff  <= cand.empty;
         best_ff.idx     <= cand.idx;
         best_ff.station <= cand.station;
         best_ff.arrive  <= cand.arrive;
      end
   end

   assign best = best_ff;

endmodule

### hw/rtl/sequential_nearest_vehicle_dispatch_unit.sv
// top level: sequencer, scan pipeline and output register of the dispatch unit
//
//   channel   direction  handshake         carries
//   req_chan  in         valid / ready     load, place or passenger request item
//   rsp_chan  out        valid / ready     one result item per request item
//   csr_*     in         write enable      vehicles_in_use count
//
// a load or place item goes from accept to the finish state, then into the result register once the slot is free
// a passenger request goes through the occupied trip read, one vehicle read a cycle,
// a drain of the scan pipeline, pickup and write-back
// reset is synchronous; the vehicle memory clears through its written flags at once
// a new item is taken while the previous result waits; a stalled result holds the sequencer
`include "assert_macros.svh"

module sequential_nearest_vehicle_dispatch_unit (
   input  logic                                clock,
   input  logic                                reset,
   snd_req_if.sink                             req_chan,
   snd_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [snd_pkg::COUNT_BITS-1:0]      csr_wr_data
);
   import snd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_OCC    = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_PICK   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [COUNT_BITS-1:0]   vehicles_in_use_ff;
   req_payload_type         item_ff;
   tick_type                parr_ff;
   veh_idx_type             scan_idx_ff, scan_idx_in;
   veh_idx_type             scan_last_ff;
   logic                    occ_rd_ff;
   trip_type                occ_ff;
   tick_type                pickup_ff;

   logic                    p1_vld_ff, p2_vld_ff, p3_vld_ff;
   logic                    pipe_busy;
   veh_idx_type             p1_idx_ff;
   cand_type                p2_ff, p3_ff;

   logic                    rsp_vld_ff, rsp_vld_in;
   rsp_payload_type         rsp_data_ff;
   rsp_payload_type         rsp_data_in;

   logic                    accept;
   logic                    slot_free;
   logic                    req_ok;
   station_type             origin, destin;
   tick_type                drop;
   logic                    do_trip, do_place, do_req;

   logic                    trip_wr_en;
   table_addr_type          trip_wr_addr, trip_rd_addr;
   trip_type                trip_rd_data;
   logic                    fleet_wr_en;
   veh_idx_type             fleet_wr_addr;
   fleet_entry_type         fleet_wr_entry, fleet_rd_entry;
   best_type                best;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_vld_ff || rsp_chan.ready;
   assign pipe_busy      = p1_vld_ff || p2_vld_ff || p3_vld_ff;

   assign origin = station_type'(item_ff.pax_origin);
   assign destin = station_type'(item_ff.pax_destin);
   assign req_ok = func_type'(req_chan.payload.func) == FUNC_REQUEST
                   && station_ok(req_chan.payload.pax_origin)
                   && station_ok(req_chan.payload.pax_destin);

   assign do_trip  = func_type'(item_ff.func) == FUNC_LOAD_TRIP
                     && station_ok(item_ff.table_row) && station_ok(item_ff.table_col);
   assign do_place = func_type'(item_ff.func) == FUNC_PLACE
                     && slot_ok(item_ff.vehicle_slot) && station_ok(item_ff.place_station);
   assign do_req   = func_type'(item_ff.func) == FUNC_REQUEST
                     && station_ok(item_ff.pax_origin) && station_ok(item_ff.pax_destin);

   assign drop = sat_add(pickup_ff, TIME_BITS'(occ_ff));

   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            scan_idx_in = '0;
            if (accept) begin
               state_in = req_ok ? ST_OCC : ST_FINISH;
            end
         end
         ST_OCC: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_idx_ff == scan_last_ff) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory port steering
   always_comb begin
      trip_wr_en     = (state_ff == ST_FINISH) && slot_free && do_trip;
      trip_wr_addr   = table_addr(station_type'(item_ff.table_row),
                                  station_type'(item_ff.table_col));
      trip_rd_addr   = (state_ff == ST_OCC) ? table_addr(origin, destin)
                                            : table_addr(fleet_rd_entry.station, origin);
      fleet_wr_en    = (state_ff == ST_FINISH) && slot_free && (do_place || do_req);
      if (do_req) begin
         fleet_wr_addr          = best.idx;
         fleet_wr_entry.station = destin;
         fleet_wr_entry.arrive  = drop;
      end else begin
         fleet_wr_addr          = VEH_BITS'(item_ff.vehicle_slot);
         fleet_wr_entry.station = station_type'(item_ff.place_station);
         fleet_wr_entry.arrive  = clamp_in(item_ff.place_arrive);
      end
   end

   always_comb begin
      rsp_data_in = '0;
      if (do_req) begin
         rsp_data_in.assigned       = 1'b1;
         rsp_data_in.chosen_vehicle = 5'(best.idx);
         rsp_data_in.start_station  = 4'(best.station);
         rsp_data_in.pickup_time    = 32'(pickup_ff);
         rsp_data_in.dropoff_time   = 32'(drop);
      end
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      if (state_ff == ST_FINISH && slot_free) begin
         rsp_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         vehicles_in_use_ff <= COUNT_RESET;
         p1_vld_ff          <= 1'b0;
         p2_vld_ff          <= 1'b0;
         p3_vld_ff          <= 1'b0;
         occ_rd_ff          <= 1'b0;
         rsp_vld_ff         <= 1'b0;
         scan_idx_ff        <= '0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         p1_vld_ff   <= (state_ff == ST_SCAN);
         p2_vld_ff   <= p1_vld_ff;
         p3_vld_ff   <= p2_vld_ff;
         occ_rd_ff   <= (state_ff == ST_OCC);
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_wr_en) begin
            vehicles_in_use_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff      <= req_chan.payload;
         parr_ff      <= clamp_in(req_chan.payload.pax_arrive);
         scan_last_ff <= count_last(vehicles_in_use_ff);
      end
      if (occ_rd_ff) begin
         occ_ff <= trip_rd_data;
      end
      // vehicle read issued, then empty trip read, then arrival sum
      p1_idx_ff      <= scan_idx_ff;
      p2_ff.idx      <= p1_idx_ff;
      p2_ff.station  <= fleet_rd_entry.station;
      p2_ff.empty    <= '0;
      p2_ff.arrive   <= fleet_rd_entry.arrive;
      p3_ff.idx      <= p2_ff.idx;
      p3_ff.station  <= p2_ff.station;
      p3_ff.empty    <= trip_rd_data;
      p3_ff.arrive   <= sat_add(p2_ff.arrive, TIME_BITS'(trip_rd_data));
      if (state_ff == ST_PICK) begin
         pickup_ff <= (best.arrive > parr_ff) ? best.arrive : parr_ff;
      end
      if (state_ff == ST_FINISH && slot_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // station read from the fleet memory must address the trip table the cycle it arrives
   snd_trip_ram u_trip_ram (
      .clock   (clock),
      .wr_en   (trip_wr_en),
      .wr_addr (trip_wr_addr),
      .wr_data (item_ff.trip_ticks),
      .rd_addr (trip_rd_addr),
      .rd_data (trip_rd_data)
   );

   snd_fleet_ram u_fleet_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (fleet_wr_en),
      .wr_addr  (fleet_wr_addr),
      .wr_entry (fleet_wr_entry),
      .rd_addr  (scan_idx_ff),
      .rd_entry (fleet_rd_entry)
   );

   snd_best_select u_best_select (
      .clock    (clock),
      .cand_vld (p3_vld_ff),
      .cand     (p3_ff),
      .parr     (parr_ff),
      .best     (best)
   );

   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_data_ff;

   `ASSERT_IMPLIES(a_scan_bound, clock, reset, p3_vld_ff, p3_ff.idx <= scan_last_ff)
   `ASSERT_IMPLIES(a_pick_drained, clock, reset, state_ff == ST_PICK, !pipe_busy)
   `ASSERT_IMPLIES(a_rsp_from_finish, clock, reset, $rose(rsp_vld_ff), $past(state_ff) == ST_FINISH)
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != ST_IDLE)

endmodule
